### sv/rrce_pkg.sv
// ----------------------------------------------------------------------------
// rrce_pkg
// Shared types and constants of the row run centroid extractor: field widths,
// register reset values, register indexes, controller states, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrce_pkg;

    localparam int RRCE_MAX_COLUMNS = 1024;

    localparam int PIXEL_W    = 8;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int RUN_W      = 11;
    localparam int VSUM_W     = 18;
    localparam int WSUM_W     = 28;
    localparam int CENTROID_W = 18;
    localparam int MEAN_W     = 16;
    localparam int FRAC_W     = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int DIV_DIVIDEND_W = WSUM_W + FRAC_W;
    localparam int DIV_DIVISOR_W  = VSUM_W;

    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd32;
    localparam logic [RUN_W-1:0]   MIN_WIDTH_RESET = 11'd2;
    localparam logic [RUN_W-1:0]   MAX_WIDTH_RESET = 11'd40;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN_WIDTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RUN_WIDTH      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CEN_GO,
        ST_CEN_RUN,
        ST_MEAN_GO,
        ST_MEAN_RUN,
        ST_EMIT
    } rrce_state_t;

    typedef enum logic {
        DIV_SEL_CENTROID,
        DIV_SEL_MEAN
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_out;
    } rrce_cmd_t;

    typedef struct packed {
        logic report;
        logic div_done;
        logic out_busy;
    } rrce_status_t;

endpackage

### sv/row_run_centroid_extractor.sv
// ----------------------------------------------------------------------------
// row_run_centroid_extractor
// Finds runs of at-or-above-threshold pixels in rows and reports each run of
// allowed width: row, extent, weighted centroid column and mean response.
// ----------------------------------------------------------------------------
// While the controller is idle, a pixel that does not close a reported run is
// taken as soon as it is valid, so such pixels stream at one beat per cycle.
// A pixel that closes a reported run holds the input after its beat until its
// result is loaded: the run passes twice through the shared bit-serial divider
// (centroid first, then mean), each pass a start state and a wait for the done
// pulse, and then the result register is loaded, later if the previous result
// beat is still waiting to be taken.
// Configuration writes are taken in every cycle and apply from the next pixel.
module row_run_centroid_extractor
    import rrce_pkg::*;
#(
    parameter int MAX_COLUMNS = RRCE_MAX_COLUMNS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIXEL_W-1:0]     s_pixel_value,
    input  logic [ROW_W-1:0]       s_row_index,
    input  logic                   s_end_of_row,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROW_W-1:0]       m_run_row,
    output logic [COL_W-1:0]       m_first_col,
    output logic [COL_W-1:0]       m_last_col,
    output logic [CENTROID_W-1:0]  m_centroid_col,
    output logic [MEAN_W-1:0]      m_avg_response
);

    rrce_cmd_t    cmd;
    rrce_status_t status;

    assign cfg_ready = 1'b1;

    rrce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrce_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_pixel_value  (s_pixel_value),
        .s_row_index    (s_row_index),
        .s_end_of_row   (s_end_of_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_row      (m_run_row),
        .m_first_col    (m_first_col),
        .m_last_col     (m_last_col),
        .m_centroid_col (m_centroid_col),
        .m_avg_response (m_avg_response)
    );

endmodule

### sv/rrce_divider.sv
// ----------------------------------------------------------------------------
// rrce_divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// A start pulse loads the operands; done pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module rrce_divider
    import rrce_pkg::*;
#(
    parameter int DIVIDEND_W = DIV_DIVIDEND_W,
    parameter int DIVISOR_W  = DIV_DIVISOR_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        rem_shift    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff         = rem_shift - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, divisor_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### sv/rrce_datapath.sv
// ----------------------------------------------------------------------------
// rrce_datapath
// Configuration registers, run tracking and sums, the captured run that
// waits for division, the shared divider, and the result register.
// ----------------------------------------------------------------------------
module rrce_datapath
    import rrce_pkg::*;
#(
    parameter int MAX_COLUMNS = RRCE_MAX_COLUMNS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rrce_cmd_t              cmd,
    output rrce_status_t           status,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [PIXEL_W-1:0]     s_pixel_value,
    input  logic [ROW_W-1:0]       s_row_index,
    input  logic                   s_end_of_row,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROW_W-1:0]       m_run_row,
    output logic [COL_W-1:0]       m_first_col,
    output logic [COL_W-1:0]       m_last_col,
    output logic [CENTROID_W-1:0]  m_centroid_col,
    output logic [MEAN_W-1:0]      m_avg_response
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);

    logic [PIXEL_W-1:0]    threshold_reg;
    logic [RUN_W-1:0]      min_width_reg;
    logic [RUN_W-1:0]      max_width_reg;

    logic [COL_W-1:0]      col_reg, col_next;
    logic                  inside_reg, inside_next;
    logic [COL_W-1:0]      start_reg, start_next;
    logic [VSUM_W-1:0]     vsum_reg, vsum_next;
    logic [WSUM_W-1:0]     wsum_reg, wsum_next;

    logic [ROW_W-1:0]      l_row_reg;
    logic [COL_W-1:0]      l_first_reg;
    logic [COL_W-1:0]      l_last_reg;
    logic [VSUM_W-1:0]     l_vsum_reg;
    logic [WSUM_W-1:0]     l_wsum_reg;
    logic [RUN_W-1:0]      l_width_reg;
    logic [CENTROID_W-1:0] cen_reg;

    logic                  m_valid_reg;
    logic [ROW_W-1:0]      m_row_reg;
    logic [COL_W-1:0]      m_first_reg;
    logic [COL_W-1:0]      m_last_reg;
    logic [CENTROID_W-1:0] m_cen_reg;
    logic [MEAN_W-1:0]     m_mean_reg;

    logic                      above;
    logic                      row_end;
    logic                      close_run;
    logic [COL_W-1:0]          last_col;
    logic [COL_W-1:0]          start_used;
    logic [VSUM_W-1:0]         vsum_base;
    logic [WSUM_W-1:0]         wsum_base;
    logic [VSUM_W-1:0]         vsum_used;
    logic [WSUM_W-1:0]         wsum_used;
    logic [PIXEL_W+COL_W-1:0]  product;
    logic [COL_W-1:0]          span;
    logic [RUN_W-1:0]          width;
    logic                      report;

    logic [DIV_DIVIDEND_W-1:0] div_dividend;
    logic [DIV_DIVISOR_W-1:0]  div_divisor;
    logic [DIV_DIVIDEND_W-1:0] div_quotient;
    logic                      div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            min_width_reg <= MIN_WIDTH_RESET;
            max_width_reg <= MAX_WIDTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RESPONSE_THRESHOLD: threshold_reg <= cfg_data[PIXEL_W-1:0];
                CFG_MIN_RUN_WIDTH:      min_width_reg <= cfg_data[RUN_W-1:0];
                CFG_MAX_RUN_WIDTH:      max_width_reg <= cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        above     = s_pixel_value >= threshold_reg;
        row_end   = s_end_of_row || (col_reg >= LAST_COL);
        vsum_base = inside_reg ? vsum_reg : '0;
        wsum_base = inside_reg ? wsum_reg : '0;
        product   = s_pixel_value * col_reg;
        if (above) begin
            start_used = inside_reg ? start_reg : col_reg;
            vsum_used  = vsum_base + VSUM_W'(s_pixel_value);
            wsum_used  = wsum_base + WSUM_W'(product);
            close_run  = row_end;
            last_col   = col_reg;
        end else begin
            start_used = start_reg;
            vsum_used  = vsum_reg;
            wsum_used  = wsum_reg;
            close_run  = inside_reg;
            last_col   = col_reg - 1'b1;
        end
        span   = last_col - start_used;
        width  = {1'b0, span} + 1'b1;
        report = close_run && (width >= min_width_reg) && (width <= max_width_reg)
                 && (vsum_used != '0);

        if (row_end) begin
            col_next    = '0;
            inside_next = 1'b0;
        end else begin
            col_next    = col_reg + 1'b1;
            inside_next = above;
        end
        start_next = start_used;
        vsum_next  = inside_next ? vsum_used : '0;
        wsum_next  = inside_next ? wsum_used : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            inside_reg <= 1'b0;
            start_reg  <= '0;
            vsum_reg   <= '0;
            wsum_reg   <= '0;
        end else if (cmd.accept) begin
            col_reg    <= col_next;
            inside_reg <= inside_next;
            start_reg  <= start_next;
            vsum_reg   <= vsum_next;
            wsum_reg   <= wsum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            l_row_reg   <= s_row_index;
            l_first_reg <= start_used;
            l_last_reg  <= last_col;
            l_vsum_reg  <= vsum_used;
            l_wsum_reg  <= wsum_used;
            l_width_reg <= width;
        end
        if (div_done && (cmd.div_sel == DIV_SEL_CENTROID)) begin
            cen_reg <= div_quotient[CENTROID_W-1:0];
        end
    end

    always_comb begin
        if (cmd.div_sel == DIV_SEL_CENTROID) begin
            div_dividend = {l_wsum_reg, FRAC_W'(0)};
            div_divisor  = l_vsum_reg;
        end else begin
            div_dividend = DIV_DIVIDEND_W'({l_vsum_reg, FRAC_W'(0)});
            div_divisor  = DIV_DIVISOR_W'(l_width_reg);
        end
    end

    rrce_divider #(
        .DIVIDEND_W (DIV_DIVIDEND_W),
        .DIVISOR_W  (DIV_DIVISOR_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_row_reg   <= l_row_reg;
            m_first_reg <= l_first_reg;
            m_last_reg  <= l_last_reg;
            m_cen_reg   <= cen_reg;
            m_mean_reg  <= div_quotient[MEAN_W-1:0];
        end
    end

    assign status.report   = report;
    assign status.div_done = div_done;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid        = m_valid_reg;
    assign m_run_row      = m_row_reg;
    assign m_first_col    = m_first_reg;
    assign m_last_col     = m_last_reg;
    assign m_centroid_col = m_cen_reg;
    assign m_avg_response = m_mean_reg;

endmodule

### sv/rrce_ctrl.sv
// ----------------------------------------------------------------------------
// rrce_ctrl
// Controller of the row run centroid extractor. It takes pixels, and for a
// reported run sequences the centroid and mean divisions and the result load.
// ----------------------------------------------------------------------------
module rrce_ctrl
    import rrce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rrce_status_t status,
    output rrce_cmd_t    cmd
);

    rrce_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.report) begin
                    state_next = ST_CEN_GO;
                end
            end
            ST_CEN_GO:   state_next = ST_CEN_RUN;
            ST_CEN_RUN: begin
                if (status.div_done) begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:  state_next = ST_MEAN_RUN;
            ST_MEAN_RUN: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_SEL_CENTROID;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_CEN_GO: begin
                cmd.div_start = 1'b1;
            end
            ST_CEN_RUN: ;
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_MEAN;
            end
            ST_MEAN_RUN: begin
                cmd.div_sel = DIV_SEL_MEAN;
            end
            ST_EMIT: begin
                cmd.div_sel  = DIV_SEL_MEAN;
                cmd.load_out = !status.out_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
